FILE: hdl/lvsc_pkg.sv
package lvsc_pkg;

    localparam int NORMAL_WIDTH = 16;
    localparam int NORMAL_FRAC  = 14;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int AXES = 3;

    typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_LIGHT_X      = 3'd0;
    localparam cfg_idx_t REG_LIGHT_Y      = 3'd1;
    localparam cfg_idx_t REG_LIGHT_Z      = 3'd2;
    localparam cfg_idx_t REG_LIGHT2_X     = 3'd3;
    localparam cfg_idx_t REG_LIGHT2_Y     = 3'd4;
    localparam cfg_idx_t REG_LIGHT2_Z     = 3'd5;
    localparam cfg_idx_t REG_LIGHT_RADIUS = 3'd6;
    localparam cfg_idx_t REG_CAPSULE_MODE = 3'd7;

    typedef enum logic [1:0] {
        KIND_FACE  = 2'd0,
        KIND_GRID  = 2'd1,
        KIND_TRI   = 2'd2,
        KIND_OTHER = 2'd3
    } surf_kind_t;

    typedef logic signed [NORMAL_WIDTH-1:0] normal_t;

    typedef struct packed {
        logic load_b;
        logic capsule;
    } lvsc_ctrl_t;

endpackage

FILE: hdl/lvsc_face.sv
module lvsc_face #(
    parameter int CW = 32
) (
    input  logic                   clk,
    input  lvsc_pkg::lvsc_ctrl_t   ctrl,
    input  lvsc_pkg::normal_t      nx,
    input  lvsc_pkg::normal_t      ny,
    input  lvsc_pkg::normal_t      nz,
    input  logic signed [CW-1:0]   pdist,
    input  logic signed [CW-1:0]   c1x,
    input  logic signed [CW-1:0]   c1y,
    input  logic signed [CW-1:0]   c1z,
    input  logic signed [CW-1:0]   c2x,
    input  logic signed [CW-1:0]   c2y,
    input  logic signed [CW-1:0]   c2z,
    input  logic [CW-2:0]          radius,
    output logic                   culled
);
    import lvsc_pkg::*;

    localparam int PW = CW + NORMAL_WIDTH;
    localparam int QW = CW + NORMAL_FRAC;
    localparam int SW = CW + NORMAL_WIDTH + 2;

    logic signed [PW-1:0] p1x_reg, p1y_reg, p1z_reg;
    logic signed [PW-1:0] p2x_reg, p2y_reg, p2z_reg;
    logic signed [QW-1:0] dist_q_reg;
    logic signed [SW-1:0] d1, d2, rpos, rneg;
    logic out1, out2, pos1, pos2;

    // dot products of both centres with the normal
    always_ff @(posedge clk)
    begin
        if (ctrl.load_b)
        begin
            p1x_reg    <= PW'(c1x) * PW'(nx);
            p1y_reg    <= PW'(c1y) * PW'(ny);
            p1z_reg    <= PW'(c1z) * PW'(nz);
            p2x_reg    <= PW'(c2x) * PW'(nx);
            p2y_reg    <= PW'(c2y) * PW'(ny);
            p2z_reg    <= PW'(c2z) * PW'(nz);
            dist_q_reg <= $signed({pdist, {NORMAL_FRAC{1'b0}}});
        end
    end

    always_comb
    begin
        rpos = SW'($signed({1'b0, radius, {NORMAL_FRAC{1'b0}}}));
        rneg = -rpos;
        d1 = SW'(p1x_reg) + SW'(p1y_reg) + SW'(p1z_reg) - SW'(dist_q_reg);
        d2 = SW'(p2x_reg) + SW'(p2y_reg) + SW'(p2z_reg) - SW'(dist_q_reg);
        pos1 = d1 > rpos;
        pos2 = d2 > rpos;
        out1 = pos1 || (d1 < rneg);
        out2 = pos2 || (d2 < rneg);
        if (ctrl.capsule)
            culled = out1 && out2 && (pos1 == pos2);
        else
            culled = out1;
    end

endmodule

FILE: hdl/lvsc_box.sv
module lvsc_box #(
    parameter int CW = 32
) (
    input  logic                   clk,
    input  lvsc_pkg::lvsc_ctrl_t   ctrl,
    input  logic signed [CW-1:0]   c1     [lvsc_pkg::AXES],
    input  logic signed [CW-1:0]   c2     [lvsc_pkg::AXES],
    input  logic signed [CW-1:0]   lo     [lvsc_pkg::AXES],
    input  logic signed [CW-1:0]   hi     [lvsc_pkg::AXES],
    input  logic [CW-2:0]          radius,
    output logic                   culled
);
    import lvsc_pkg::*;

    localparam int EW = CW + 2;

    logic signed [EW-1:0] rext;
    logic [AXES-1:0] above1_reg, below1_reg, above2_reg, below2_reg;
    logic [AXES-1:0] axis_out;

    assign rext = EW'($signed({1'b0, radius}));

    for (genvar i = 0; i < AXES; i++)
    begin : g_axis
        always_ff @(posedge clk)
        begin
            if (ctrl.load_b)
            begin
                above1_reg[i] <= (EW'(c1[i]) - rext) > EW'(hi[i]);
                below1_reg[i] <= (EW'(c1[i]) + rext) < EW'(lo[i]);
                above2_reg[i] <= (EW'(c2[i]) - rext) > EW'(hi[i]);
                below2_reg[i] <= (EW'(c2[i]) + rext) < EW'(lo[i]);
            end
        end

        assign axis_out[i] = ctrl.capsule
            ? ((above1_reg[i] && above2_reg[i]) || (below1_reg[i] && below2_reg[i]))
            : (above1_reg[i] || below1_reg[i]);
    end

    assign culled = |axis_out;

endmodule

FILE: hdl/light_volume_surface_cull.sv
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   surf_kind, normal_*, plane_dist, min_*, max_*
// output    out        out_valid / out_stall culled
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one surface per cycle unless out_stall holds the pipeline
// stages: input register, products and box compares, result register
// rst_n clears all valid flags and the light registers
// out_stall backs up through the stages; in_stall rises only when all three are full
// cfg_ready is always high
module light_volume_surface_cull #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     surf_kind,
    input  logic signed [15:0]             normal_x,
    input  logic signed [15:0]             normal_y,
    input  logic signed [15:0]             normal_z,
    input  logic signed [COORD_WIDTH-1:0]  plane_dist,
    input  logic signed [COORD_WIDTH-1:0]  min_x,
    input  logic signed [COORD_WIDTH-1:0]  min_y,
    input  logic signed [COORD_WIDTH-1:0]  min_z,
    input  logic signed [COORD_WIDTH-1:0]  max_x,
    input  logic signed [COORD_WIDTH-1:0]  max_y,
    input  logic signed [COORD_WIDTH-1:0]  max_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           culled,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  lvsc_pkg::cfg_idx_t             cfg_index,
    input  logic [COORD_WIDTH-1:0]         cfg_data
);
    import lvsc_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic signed [CW-1:0] light_x_reg, light_y_reg, light_z_reg;
    logic signed [CW-1:0] light2_x_reg, light2_y_reg, light2_z_reg;
    logic [CW-2:0]        light_radius_reg;
    logic                 capsule_mode_reg;

    logic va_reg, vb_reg, vc_reg;
    logic va_next, vb_next, vc_next;
    logic adv_a, adv_b, adv_c, load_b, load_c, accept;

    surf_kind_t           kind_a_reg, kind_b_reg;
    normal_t              nx_reg, ny_reg, nz_reg;
    logic signed [CW-1:0] dist_reg;
    logic signed [CW-1:0] lo_reg [AXES];
    logic signed [CW-1:0] hi_reg [AXES];
    logic signed [CW-1:0] c1 [AXES];
    logic signed [CW-1:0] c2 [AXES];

    logic       culled_reg, culled_next;
    logic       face_culled, box_culled;
    lvsc_ctrl_t ctrl;

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg      <= '0;
            light_y_reg      <= '0;
            light_z_reg      <= '0;
            light2_x_reg     <= '0;
            light2_y_reg     <= '0;
            light2_z_reg     <= '0;
            light_radius_reg <= '0;
            capsule_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LIGHT_X:      light_x_reg      <= $signed(cfg_data);
                REG_LIGHT_Y:      light_y_reg      <= $signed(cfg_data);
                REG_LIGHT_Z:      light_z_reg      <= $signed(cfg_data);
                REG_LIGHT2_X:     light2_x_reg     <= $signed(cfg_data);
                REG_LIGHT2_Y:     light2_y_reg     <= $signed(cfg_data);
                REG_LIGHT2_Z:     light2_z_reg     <= $signed(cfg_data);
                REG_LIGHT_RADIUS: light_radius_reg <= cfg_data[CW-2:0];
                REG_CAPSULE_MODE: capsule_mode_reg <= cfg_data[0];
            endcase
        end
    end

    // pipeline flow control
    always_comb
    begin
        adv_c   = !vc_reg || !out_stall;
        load_c  = vb_reg && adv_c;
        adv_b   = !vb_reg || adv_c;
        load_b  = va_reg && adv_b;
        adv_a   = !va_reg || adv_b;
        accept  = in_valid && adv_a;
        va_next = accept || (va_reg && !adv_b);
        vb_next = load_b || (vb_reg && !adv_c);
        vc_next = load_c || (vc_reg && out_stall);
    end

    assign in_stall = !adv_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_a_reg <= surf_kind_t'(surf_kind);
            nx_reg     <= normal_x;
            ny_reg     <= normal_y;
            nz_reg     <= normal_z;
            dist_reg   <= plane_dist;
            lo_reg[0]  <= min_x;
            lo_reg[1]  <= min_y;
            lo_reg[2]  <= min_z;
            hi_reg[0]  <= max_x;
            hi_reg[1]  <= max_y;
            hi_reg[2]  <= max_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
            kind_b_reg <= kind_a_reg;
    end

    assign c1[0] = light_x_reg;
    assign c1[1] = light_y_reg;
    assign c1[2] = light_z_reg;
    assign c2[0] = light2_x_reg;
    assign c2[1] = light2_y_reg;
    assign c2[2] = light2_z_reg;

    assign ctrl.load_b  = load_b;
    assign ctrl.capsule = capsule_mode_reg;

    lvsc_face #(
        .CW (CW)
    ) u_face (
        .clk    (clk),
        .ctrl   (ctrl),
        .nx     (nx_reg),
        .ny     (ny_reg),
        .nz     (nz_reg),
        .pdist  (dist_reg),
        .c1x    (light_x_reg),
        .c1y    (light_y_reg),
        .c1z    (light_z_reg),
        .c2x    (light2_x_reg),
        .c2y    (light2_y_reg),
        .c2z    (light2_z_reg),
        .radius (light_radius_reg),
        .culled (face_culled)
    );

    lvsc_box #(
        .CW (CW)
    ) u_box (
        .clk    (clk),
        .ctrl   (ctrl),
        .c1     (c1),
        .c2     (c2),
        .lo     (lo_reg),
        .hi     (hi_reg),
        .radius (light_radius_reg),
        .culled (box_culled)
    );

    // result select
    always_comb
    begin
        unique case (kind_b_reg)
            KIND_FACE:  culled_next = face_culled;
            KIND_GRID:  culled_next = box_culled;
            KIND_TRI:   culled_next = box_culled;
            KIND_OTHER: culled_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_c)
            culled_reg <= culled_next;
    end

    assign out_valid = vc_reg;
    assign culled    = culled_reg;

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (va_reg && vb_reg && vc_reg && out_stall) |-> in_stall)
        else $error("input taken while pipeline full and stalled");

    a_b_to_c: assert property (@(posedge clk) disable iff (!rst_n)
        (vb_reg && !vc_reg) |=> vc_reg)
        else $error("middle stage did not move into empty result stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !vb_reg) |=> !out_valid)
        else $error("result repeated after being taken");

endmodule

FILE: tb/sv/light_volume_surface_cull_checker.sv
`timescale 1ns / 1ps

module light_volume_surface_cull_checker #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    surf_kind,
    input  logic signed [15:0]            normal_x,
    input  logic signed [15:0]            normal_y,
    input  logic signed [15:0]            normal_z,
    input  logic signed [COORD_WIDTH-1:0] plane_dist,
    input  logic signed [COORD_WIDTH-1:0] min_x,
    input  logic signed [COORD_WIDTH-1:0] min_y,
    input  logic signed [COORD_WIDTH-1:0] min_z,
    input  logic signed [COORD_WIDTH-1:0] max_x,
    input  logic signed [COORD_WIDTH-1:0] max_y,
    input  logic signed [COORD_WIDTH-1:0] max_z,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          culled,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  lvsc_pkg::cfg_idx_t            cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    output int                            mismatches,
    output int                            outstanding
);
    import lvsc_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam longint NORMAL_ONE = longint'(1) << NORMAL_FRAC;

    coord_t                 near_end [AXES];
    coord_t                 far_end [AXES];
    logic [COORD_WIDTH-2:0] radius;
    logic                   capsule;
    logic                   cull_flags_due [$];

    // -1 below the slab, +1 above it, 0 within reach of the plane
    function automatic int plane_side(coord_t cx, coord_t cy, coord_t cz, coord_t pdist);
        longint acc;
        longint lim;
        acc = longint'(cx) * longint'(normal_x) + longint'(cy) * longint'(normal_y)
            + longint'(cz) * longint'(normal_z) - longint'(pdist) * NORMAL_ONE;
        lim = longint'(radius) * NORMAL_ONE;
        if (acc < -lim)
            return -1;
        if (acc > lim)
            return 1;
        return 0;
    endfunction

    function automatic logic beyond_axis(coord_t c1, coord_t c2, coord_t lo, coord_t hi);
        longint r;
        logic   above;
        logic   below;
        r = longint'(radius);
        above = longint'(c1) - r > longint'(hi);
        below = longint'(c1) + r < longint'(lo);
        if (!capsule)
            return above || below;
        return (above && longint'(c2) - r > longint'(hi))
            || (below && longint'(c2) + r < longint'(lo));
    endfunction

    function automatic logic light_misses_request();
        int s1;
        int s2;
        case (surf_kind_t'(surf_kind))
            KIND_FACE:
            begin
                s1 = plane_side(near_end[0], near_end[1], near_end[2], plane_dist);
                if (!capsule)
                    return s1 != 0;
                s2 = plane_side(far_end[0], far_end[1], far_end[2], plane_dist);
                return s1 != 0 && s1 == s2;
            end
            KIND_GRID, KIND_TRI:
                return beyond_axis(near_end[0], far_end[0], min_x, max_x)
                    || beyond_axis(near_end[1], far_end[1], min_y, max_y)
                    || beyond_axis(near_end[2], far_end[2], min_z, max_z);
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic want, logic got);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
            $display("%0t: %s: expected culled %b, actual %b", $realtime, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic due;
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                near_end[a] = '0;
                far_end[a] = '0;
            end
            radius = '0;
            capsule = 1'b0;
            cull_flags_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LIGHT_X:      near_end[0] = cfg_data;
                    REG_LIGHT_Y:      near_end[1] = cfg_data;
                    REG_LIGHT_Z:      near_end[2] = cfg_data;
                    REG_LIGHT2_X:     far_end[0] = cfg_data;
                    REG_LIGHT2_Y:     far_end[1] = cfg_data;
                    REG_LIGHT2_Z:     far_end[2] = cfg_data;
                    REG_LIGHT_RADIUS: radius = cfg_data[COORD_WIDTH-2:0];
                    REG_CAPSULE_MODE: capsule = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (cull_flags_due.size() == 0)
                    flag_mismatch("result with no request waiting", 1'bx, culled);
                else
                begin
                    due = cull_flags_due.pop_front();
                    if (culled !== due)
                        flag_mismatch("culled flag wrong", due, culled);
                end
            end
            if (in_valid && !in_stall)
                cull_flags_due.push_back(light_misses_request());
            outstanding <= cull_flags_due.size();
        end
    end

endmodule

FILE: tb/sv/light_volume_surface_cull_test.sv
`timescale 1ns / 1ps

module light_volume_surface_cull_test;
    import lvsc_pkg::*;

    localparam int CW = 32;
    localparam int HOLD_CYCLES = 150;
    localparam int ROUNDS = 8;
    localparam int ROUND_ITEMS = 205;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [CW-2:0] radius_t;

    typedef struct packed {
        surf_kind_t              kind;
        normal_t                 nx;
        normal_t                 ny;
        normal_t                 nz;
        coord_t                  pdist;
        logic [AXES-1:0][CW-1:0] lo;
        logic [AXES-1:0][CW-1:0] hi;
    } surface_t;

    localparam coord_t  COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t  COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam radius_t RADIUS_MAX = '1;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    logic [1:0]     surf_kind = '0;
    normal_t        normal_x = '0;
    normal_t        normal_y = '0;
    normal_t        normal_z = '0;
    coord_t         plane_dist = '0;
    coord_t         min_x = '0;
    coord_t         min_y = '0;
    coord_t         min_z = '0;
    coord_t         max_x = '0;
    coord_t         max_y = '0;
    coord_t         max_z = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    logic           culled;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    cfg_idx_t       cfg_index = '0;
    logic [CW-1:0]  cfg_data = '0;
    int             mismatches;
    int             outstanding;

    bit             steady = 1'b0;
    int             hold_calls = 0;
    int             holds_served = 0;
    int             hold_left = 0;
    coord_t         light_a [AXES];
    coord_t         light_b [AXES];
    radius_t        light_r;
    logic           light_caps;

    always #2 clk = ~clk;

    light_volume_surface_cull #(.COORD_WIDTH(CW)) u_top (.*);

    light_volume_surface_cull_checker #(.COORD_WIDTH(CW)) u_checker (.*);

    // result side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_calls != holds_served)
        begin
            holds_served <= hold_calls;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !steady && $urandom_range(99) < 17;
    end

    function automatic coord_t q12(int whole);
        return coord_t'(longint'(whole) <<< 12);
    endfunction

    function automatic longint spread(longint m);
        longint unsigned u;
        u = {$urandom, $urandom};
        return longint'(u % longint'(2 * m + 1)) - m;
    endfunction

    function automatic coord_t extreme_coord();
        case ($urandom_range(3))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic surface_t noise_surface();
        surface_t s;
        s.kind = surf_kind_t'($urandom_range(3));
        s.nx = normal_t'($urandom);
        s.ny = normal_t'($urandom);
        s.nz = normal_t'($urandom);
        s.pdist = $urandom;
        for (int a = 0; a < AXES; a++)
        begin
            s.lo[a] = $urandom;
            s.hi[a] = $urandom;
        end
        return s;
    endfunction

    function automatic surface_t face(int nx, int ny, int nz, coord_t pdist);
        surface_t s;
        s = noise_surface();
        s.kind = KIND_FACE;
        s.nx = normal_t'(nx);
        s.ny = normal_t'(ny);
        s.nz = normal_t'(nz);
        s.pdist = pdist;
        return s;
    endfunction

    function automatic surface_t box(surf_kind_t kind, coord_t lx, coord_t ly, coord_t lz,
                                     coord_t hx, coord_t hy, coord_t hz);
        surface_t s;
        s = noise_surface();
        s.kind = kind;
        s.lo = {lz, ly, lx};
        s.hi = {hz, hy, hx};
        return s;
    endfunction

    // mostly planes and boxes placed near the light so both outcomes are common
    function automatic surface_t random_surface();
        surface_t s;
        coord_t   c [AXES];
        normal_t  n [AXES];
        longint   m;
        longint   proj;
        longint   lo;
        s = noise_surface();
        m = 2 * longint'(light_r) + 64;
        for (int a = 0; a < AXES; a++)
        begin
            c[a] = (light_caps && $urandom_range(1)) ? light_b[a] : light_a[a];
            if ($urandom_range(7) != 0)
                n[a] = normal_t'(int'($urandom_range(32768)) - 16384);
            else
                n[a] = normal_t'($urandom);
        end
        s.nx = n[0];
        s.ny = n[1];
        s.nz = n[2];
        if ($urandom_range(7) != 0)
        begin
            proj = (longint'(c[0]) * longint'(n[0]) + longint'(c[1]) * longint'(n[1])
                  + longint'(c[2]) * longint'(n[2])) >>> NORMAL_FRAC;
            s.pdist = coord_t'(proj + spread(m));
        end
        if ($urandom_range(7) != 0)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                lo = longint'(c[a]) + spread(m);
                s.lo[a] = coord_t'(lo);
                s.hi[a] = coord_t'(lo + spread(m) + m / 2);
            end
        end
        return s;
    endfunction

    task automatic offer(surface_t s);
        if (!steady)
        begin
            while ($urandom_range(99) < 17)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        surf_kind <= s.kind;
        normal_x <= s.nx;
        normal_y <= s.ny;
        normal_z <= s.nz;
        plane_dist <= s.pdist;
        min_x <= s.lo[0];
        min_y <= s.lo[1];
        min_z <= s.lo[2];
        max_x <= s.hi[0];
        max_y <= s.hi[1];
        max_z <= s.hi[2];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // unused upper bits of radius and mode carry noise
    task automatic set_lights(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                              coord_t bz, radius_t r, logic caps);
        logic [CW-1:0] junk;
        junk = $urandom;
        write_reg(REG_LIGHT_X, ax);
        write_reg(REG_LIGHT_Y, ay);
        write_reg(REG_LIGHT_Z, az);
        write_reg(REG_LIGHT2_X, bx);
        write_reg(REG_LIGHT2_Y, by);
        write_reg(REG_LIGHT2_Z, bz);
        write_reg(REG_LIGHT_RADIUS, {junk[CW-1], r});
        write_reg(REG_CAPSULE_MODE, {junk[CW-1:1], caps});
        cfg_valid <= 1'b0;
        light_a = '{ax, ay, az};
        light_b = '{bx, by, bz};
        light_r = r;
        light_caps = caps;
    endtask

    task automatic random_lights(int style);
        coord_t  a [AXES];
        coord_t  b [AXES];
        radius_t r;
        for (int i = 0; i < AXES; i++)
        begin
            case (style)
                0:
                begin
                    a[i] = coord_t'(spread(longint'(256) << 12));
                    b[i] = coord_t'(longint'(a[i]) + spread(longint'(32) << 12));
                end
                1:
                begin
                    a[i] = $urandom;
                    b[i] = $urandom;
                end
                default:
                begin
                    a[i] = extreme_coord();
                    b[i] = extreme_coord();
                end
            endcase
        end
        case (style)
            0:       r = radius_t'($urandom_range(16 << 12));
            1:       r = radius_t'($urandom);
            default: r = $urandom_range(1) ? RADIUS_MAX : '0;
        endcase
        set_lights(a[0], a[1], a[2], b[0], b[1], b[2], r, 1'($urandom_range(1)));
    endtask

    initial
    begin
        int style;
        for (int a = 0; a < AXES; a++)
        begin
            light_a[a] = '0;
            light_b[a] = '0;
        end
        light_r = '0;
        light_caps = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: point light at the origin
        offer(face(16384, 0, 0, 0));
        offer(face(16384, 0, 0, 1));
        offer(box(KIND_GRID, 0, 0, 0, 0, 0, 0));
        offer('1);

        // sphere of radius 2 at (10, -5, 3)
        drain();
        set_lights(q12(10), q12(-5), q12(3), '0, '0, '0, radius_t'(2 << 12), 1'b0);
        offer(face(16384, 0, 0, q12(10)));
        offer(face(16384, 0, 0, q12(12)));
        offer(face(16384, 0, 0, q12(12) + 1));
        offer(face(16384, 0, 0, q12(8)));
        offer(face(16384, 0, 0, q12(8) - 1));
        offer(face(-16384, -16384, -16384, COORD_MIN));
        offer(face(16384, 16384, 16384, COORD_MAX));
        offer(face(-32768, 32767, 16'sh5555, $urandom));
        offer(box(KIND_TRI, 0, q12(-10), 0, q12(20), 0, q12(10)));
        offer(box(KIND_GRID, q12(12), q12(-10), 0, q12(20), 0, q12(10)));
        offer(box(KIND_GRID, q12(12) + 1, q12(-10), 0, q12(20), 0, q12(10)));
        offer(box(KIND_TRI, 0, q12(-20), 0, q12(20), q12(-7), q12(10)));
        offer(box(KIND_TRI, 0, q12(-20), 0, q12(20), q12(-7) - 1, q12(10)));
        offer(box(KIND_GRID, q12(20), q12(20), q12(20), 0, 0, 0));
        offer(box(KIND_TRI, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        offer(box(KIND_OTHER, q12(50), q12(50), q12(50), q12(60), q12(60), q12(60)));

        // capsule from the origin to (8, 0, 0), radius 1
        drain();
        set_lights('0, '0, '0, q12(8), '0, '0, radius_t'(1 << 12), 1'b1);
        offer(face(16384, 0, 0, q12(4)));
        offer(face(16384, 0, 0, q12(-2)));
        offer(box(KIND_GRID, q12(3), q12(-1), q12(-1), q12(5), q12(1), q12(1)));
        offer(box(KIND_TRI, q12(10), q12(-1), q12(-1), q12(12), q12(1), q12(1)));

        drain();
        set_lights(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                   RADIUS_MAX, 1'b1);
        offer(face(-16384, 16384, -16384, COORD_MAX));
        offer(box(KIND_TRI, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));

        drain();
        set_lights(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, '0, 1'b0);
        offer(face(16384, 16384, 16384, COORD_MIN));
        offer(box(KIND_GRID, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));

        for (int round = 0; round < ROUNDS; round++)
        begin
            drain();
            style = (round % 4 == 1) ? 2 : ((round % 4 == 3) ? 1 : 0);
            random_lights(style);
            steady = (round == 2 || round == 4);
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                // long result hold-off while requests keep coming
                if (round == 4 && n == 40)
                    hold_calls = hold_calls + 1;
                if (round == 5 && n == 100)
                    drain();
                offer(random_surface());
            end
        end

        steady = 1'b0;
        drain();
        repeat (6) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lvsc_pkg.sv
hdl/lvsc_face.sv
hdl/lvsc_box.sv
hdl/light_volume_surface_cull.sv
tb/sv/light_volume_surface_cull_checker.sv
tb/sv/light_volume_surface_cull_test.sv
